>>> src/cia_pkg.sv
package cia_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int PORT_WIDTH = 32;
    localparam int STAGES     = DATA_WIDTH;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_DIV = 3'd2,
        OP_MUL = 3'd3,
        OP_REM = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DIV_ZERO  = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_TOO_BIG   = 3'd3,
        ST_TOO_SMALL = 3'd4
    } status_t;

    // Beat carried from cell to cell along the chain
    typedef struct packed {
        logic                    valid;
        logic [2:0]              code;
        logic                    neg_q;     // quotient sign
        logic                    neg_r;     // remainder sign (dividend)
        logic [DATA_WIDTH-1:0]   divisor;   // magnitude
        logic [DATA_WIDTH-1:0]   quot;      // dividend bits shifting out, quotient in
        logic [DATA_WIDTH:0]     rem;       // partial remainder
        logic [2*DATA_WIDTH+1:0] wide;      // add/sub/mul result
        logic [2:0]              status;    // pre-decided status, ST_OK if pending
    } beat_t;

endpackage

>>> src/cia_cell.sv
// One restoring-division step; other operations ride along unchanged.
module cia_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  cia_pkg::beat_t din,
    output cia_pkg::beat_t dout
);

    cia_pkg::beat_t              dout_reg;
    cia_pkg::beat_t              dout_next;
    logic [cia_pkg::DATA_WIDTH:0] trial;
    logic [cia_pkg::DATA_WIDTH:0] diff;

    always_comb
    begin
        dout_next = din;
        trial = {din.rem[cia_pkg::DATA_WIDTH-1:0], din.quot[cia_pkg::DATA_WIDTH-1]};
        diff  = trial - {1'b0, din.divisor};
        if (!diff[cia_pkg::DATA_WIDTH])
        begin
            dout_next.rem  = diff;
            dout_next.quot = {din.quot[cia_pkg::DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            dout_next.rem  = trial;
            dout_next.quot = {din.quot[cia_pkg::DATA_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else if (advance)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

>>> src/cia_front.sv
// Entry stage: decode, add/sub/mul, operand magnitudes for the divide chain.
module cia_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                in_valid,
    input  logic signed [cia_pkg::PORT_WIDTH-1:0] operand_a,
    input  logic signed [cia_pkg::PORT_WIDTH-1:0] operand_b,
    input  logic [2:0]                          req_type,
    output cia_pkg::beat_t                      dout
);

    localparam int DW = cia_pkg::DATA_WIDTH;

    cia_pkg::beat_t             dout_reg;
    cia_pkg::beat_t             dout_next;
    logic signed [DW-1:0]       a;
    logic signed [DW-1:0]       b;
    logic signed [2*DW+1:0]     a_x;
    logic signed [2*DW+1:0]     b_x;
    logic signed [2*DW-1:0]     prod;
    logic [DW-1:0]              a_mag;
    logic [DW-1:0]              b_mag;

    always_comb
    begin
        a     = operand_a[DW-1:0];
        b     = operand_b[DW-1:0];
        a_x   = (2*DW+2)'(a);
        b_x   = (2*DW+2)'(b);
        prod  = a * b;
        a_mag = a[DW-1] ? DW'(-a) : a;
        b_mag = b[DW-1] ? DW'(-b) : b;

        dout_next         = '0;
        dout_next.valid   = in_valid;
        dout_next.code    = req_type;
        dout_next.neg_q   = a[DW-1] ^ b[DW-1];
        dout_next.neg_r   = a[DW-1];
        dout_next.divisor = b_mag;
        dout_next.quot    = a_mag;
        dout_next.status  = cia_pkg::ST_OK;
        case (req_type)
            cia_pkg::OP_ADD: dout_next.wide = a_x + b_x;
            cia_pkg::OP_SUB: dout_next.wide = a_x - b_x;
            cia_pkg::OP_MUL: dout_next.wide = (2*DW+2)'(prod);
            cia_pkg::OP_DIV, cia_pkg::OP_REM:
            begin
                if (b == '0)
                    dout_next.status = cia_pkg::ST_DIV_ZERO;
            end
            default: dout_next.status = cia_pkg::ST_UNKNOWN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else if (advance)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

>>> src/cia_back.sv
// Exit stage: fix signs, range check, hold the result beat.
module cia_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  cia_pkg::beat_t                       din,
    output logic                                 out_valid,
    output logic signed [cia_pkg::PORT_WIDTH-1:0] value,
    output logic [2:0]                           status
);

    localparam int DW = cia_pkg::DATA_WIDTH;
    localparam int WW = 2*DW+2;

    logic                       valid_reg;
    logic [cia_pkg::PORT_WIDTH-1:0] value_reg;
    logic [cia_pkg::PORT_WIDTH-1:0] value_next;
    logic [2:0]                 status_reg;
    logic [2:0]                 status_next;
    logic signed [WW-1:0]       r;
    logic signed [WW-1:0]       maxv;
    logic signed [WW-1:0]       minv;
    logic [WW-1:0]              q_w;
    logic [WW-1:0]              m_w;

    always_comb
    begin
        maxv = WW'((64'sd1 <<< (DW-1)) - 64'sd1);
        minv = -maxv - WW'(1);
        q_w  = WW'(din.quot);
        m_w  = WW'(din.rem[DW-1:0]);
        case (din.code)
            cia_pkg::OP_DIV: r = din.neg_q ? -q_w : q_w;
            cia_pkg::OP_REM: r = din.neg_r ? -m_w : m_w;
            default:         r = din.wide;
        endcase

        status_next = din.status;
        if (status_next == cia_pkg::ST_OK)
        begin
            if (r > maxv)
                status_next = cia_pkg::ST_TOO_BIG;
            else if (r < minv)
                status_next = cia_pkg::ST_TOO_SMALL;
        end
        if (status_next == cia_pkg::ST_OK)
            value_next = cia_pkg::PORT_WIDTH'(r[DW-1:0]);
        else
            value_next = '0;
        if (DW < cia_pkg::PORT_WIDTH && status_next == cia_pkg::ST_OK)
            value_next = cia_pkg::PORT_WIDTH'($signed(r[DW-1:0]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

>>> src/checked_integer_alu.sv
// Checked signed integer ALU: add, subtract, multiply, divide and remainder on
// the low DATA_WIDTH bits of each operand, with range-checked result and status.
// Fully pipelined: one beat accepted per cycle unless the output stalls; beats
// pass the entry stage and a chain of restoring-division cells, one quotient
// bit per cell; all operations travel the same chain so results stay in order.
// A stall on the output freezes the whole pipe, so in_stall follows out_stall while out_valid is high.
module checked_integer_alu (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [cia_pkg::PORT_WIDTH-1:0] operand_a,
    input  logic signed [cia_pkg::PORT_WIDTH-1:0] operand_b,
    input  logic [2:0]                           req_type,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [cia_pkg::PORT_WIDTH-1:0] value,
    output logic [2:0]                           status
);

    logic           advance;
    cia_pkg::beat_t chain [cia_pkg::STAGES+1];

    // Advance whenever the output slot is free or being taken
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    cia_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .req_type (req_type),
        .dout     (chain[0])
    );

    for (genvar i = 0; i < cia_pkg::STAGES; i++)
    begin : g_cell
        cia_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .advance(advance),
            .din    (chain[i]),
            .dout   (chain[i+1])
        );
    end

    cia_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .din      (chain[cia_pkg::STAGES]),
        .out_valid(out_valid),
        .value    (value),
        .status   (status)
    );

endmodule

>>> src/cia_checker.sv
module cia_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [cia_pkg::PORT_WIDTH-1:0] value,
    input logic [2:0]                           status
);

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != cia_pkg::ST_OK |-> value == '0)
        else $error("nonzero value with error status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= cia_pkg::ST_TOO_SMALL)
        else $error("status code out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("stalled result beat changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value    (value),
    .status   (status)
);
